// ===== rtl/core/dtpm_pkg.sv =====
// Shared types and constants for the deformed triangle point map.
`default_nettype none
package dtpm_pkg;

   localparam int IDX_BITS    = 11;
   localparam int CORNER_BITS = 10;
   localparam int CNT_BITS    = 12;
   localparam int TRI_BITS    = 3 * CORNER_BITS;
   localparam int WFRAC       = 30;
   localparam int QBITS       = WFRAC + 1;

   typedef enum logic [1:0] {
      REQ_REST   = 2'd0,
      REQ_DEF    = 2'd1,
      REQ_TRI    = 2'd2,
      REQ_QUERY  = 2'd3
   } dtpm_req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRI,
      ST_VTX,
      ST_ISSUE,
      ST_WAIT,
      ST_STORE,
      ST_DG,
      ST_CHK,
      ST_DIVA,
      ST_DIVA_RUN,
      ST_DIVB,
      ST_DIVB_RUN,
      ST_WG,
      ST_OUT
   } dtpm_state_type;

   typedef struct packed {
      logic rest_we;
      logic def_we;
      logic tri_we;
      logic tri_re;
      logic vtx_re;
   } dtpm_mem_ctl_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic first;
   } dtpm_mac_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/core/deformed_triangle_point_map.sv =====
// Top level: sequencer, registers and handshakes of the triangle point map.
// Usage:
//  - req channel (valid/ready): req_type selects a rest vertex write, a deformed
//    vertex write, a triangle write or a query. Writes give no response. A query
//    walks triangles 0 .. min(triangle_count, MAX_TRIANGLES)-1 in order.
//  - rsp channel (valid/ready): one item per query: rsp_found and the mapped
//    point, all zero when no triangle contains the query point.
//  - csr channel: writes triangle_count; write it only while the block is idle.
//  - Per triangle the sequencer fetches corners and forms the three
//    determinants through the shared multiply-accumulate unit; a containing
//    triangle adds two divider runs, the third weight and nine blend
//    products. req_ready is low for the whole query.
//  - The result waits in an output register; a stalled receiver holds the
//    finished query in the output state, while writes are accepted as soon as
//    the sequencer is idle.
//  - Reset (synchronous) clears control state and triangle_count; memory
//    contents are undefined until written.
`default_nettype none
module deformed_triangle_point_map import dtpm_pkg::*; #(
   parameter int MAX_VERTICES  = 1024,
   parameter int MAX_TRIANGLES = 2048,
   parameter int COORD_BITS    = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [1:0]                   req_type,
   input  wire  [IDX_BITS-1:0]          req_entry_index,
   input  wire  signed [COORD_BITS-1:0] req_coord_x,
   input  wire  signed [COORD_BITS-1:0] req_coord_y,
   input  wire  signed [COORD_BITS-1:0] req_coord_z,
   input  wire  [CORNER_BITS-1:0]       req_corner_first,
   input  wire  [CORNER_BITS-1:0]       req_corner_second,
   input  wire  [CORNER_BITS-1:0]       req_corner_third,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_found,
   output logic signed [COORD_BITS-1:0] rsp_mapped_x,
   output logic signed [COORD_BITS-1:0] rsp_mapped_y,
   output logic signed [COORD_BITS-1:0] rsp_mapped_z,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [CNT_BITS-1:0]          csr_triangle_count
);

   localparam int CB   = COORD_BITS;
   localparam int MW   = (CB + 1 > 32) ? CB + 1 : 32;
   localparam int AW   = 2 * MW + 4;
   localparam int DETW = 2 * CB + 5;
   localparam int VAW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int TAW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int TCW  = $clog2(MAX_TRIANGLES + 1);
   localparam int NW   = (TCW > CNT_BITS) ? TCW : CNT_BITS;
   localparam logic signed [AW-1:0] OMAX = (AW'(1) << (CB - 1)) - AW'(1);
   localparam logic signed [AW-1:0] OMIN = ~OMAX;
   localparam logic signed [AW-1:0] RHALF = AW'(1) << (WFRAC - 1);

   dtpm_state_type state_ff, state_in;

   logic [CNT_BITS-1:0]   count_ff;
   logic [TCW-1:0]        t_ff;
   logic [TCW-1:0]        n_ff;
   logic [2:0]            grp_ff;
   logic [1:0]            cnt_ff;
   logic signed [CB-1:0]  px_ff, py_ff;
   logic signed [CB-1:0]  rx_ff [3];
   logic signed [CB-1:0]  ry_ff [3];
   logic signed [CB-1:0]  dx_ff [3];
   logic signed [CB-1:0]  dy_ff [3];
   logic signed [CB-1:0]  dz_ff [3];
   logic [2:0]            oob_ff;
   logic signed [DETW-1:0] d_ff, da_ff, db_ff, dg_ff;
   logic [QBITS-1:0]      wa_ff, wb_ff, wg_ff;
   logic signed [CB-1:0]  ox_ff, oy_ff, oz_ff;
   logic                  fnd_ff;
   logic                  rsp_valid_ff, rsp_found_ff;
   logic signed [CB-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic                  req_acc;
   logic                  qry_acc;
   logic                  vidx_ok, tidx_ok;
   logic [NW-1:0]         cnt_ext, lim;
   logic                  last_tri;
   logic                  tri_ok;
   logic                  out_load;
   logic [CORNER_BITS-1:0] corner_sel;
   logic                  corner_oob;
   dtpm_mem_ctl_type      mem_ctl;
   dtpm_mac_ctl_type      mac_ctl;
   logic signed [MW-1:0]  ua, va, ub, vb;
   logic signed [CB-1:0]  c0, c1, c2;
   logic signed [AW-1:0]  acc;
   logic signed [AW-1:0]  rnd, sh;
   logic signed [CB-1:0]  sat_val;
   logic                  div_start, div_busy;
   logic [DETW-1:0]       div_num, div_den;
   logic [QBITS-1:0]      div_q;
   logic signed [CB-1:0]  rest_x_q, rest_y_q, def_x_q, def_y_q, def_z_q;
   logic [TRI_BITS-1:0]   tri_q;

   function automatic logic agrees(input logic sd, input logic signed [DETW-1:0] v);
      return (v == '0) || (v[DETW-1] == sd);
   endfunction

   function automatic logic [DETW-1:0] mag(input logic signed [DETW-1:0] v);
      return v[DETW-1] ? DETW'(-v) : DETW'(v);
   endfunction

   // ---- handshake and decode ----
   always_comb begin
      req_acc  = req_valid && req_ready;
      qry_acc  = req_acc && (req_type == REQ_QUERY);
      vidx_ok  = int'(req_entry_index) < MAX_VERTICES;
      tidx_ok  = int'(req_entry_index) < MAX_TRIANGLES;
      cnt_ext  = NW'(count_ff);
      lim      = (cnt_ext > NW'(MAX_TRIANGLES)) ? NW'(MAX_TRIANGLES) : cnt_ext;
      last_tri = (t_ff + TCW'(1)) == n_ff;
      tri_ok   = (d_ff != '0) && agrees(d_ff[DETW-1], da_ff)
                 && agrees(d_ff[DETW-1], db_ff) && agrees(d_ff[DETW-1], dg_ff);
      out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
      case (cnt_ff)
         2'd0:    corner_sel = tri_q[0 +: CORNER_BITS];
         2'd1:    corner_sel = tri_q[CORNER_BITS +: CORNER_BITS];
         default: corner_sel = tri_q[2*CORNER_BITS +: CORNER_BITS];
      endcase
      corner_oob = int'(corner_sel) >= MAX_VERTICES;
      rnd = acc + RHALF;
      sh  = rnd >>> WFRAC;
      if (sh > OMAX) begin
         sat_val = OMAX[CB-1:0];
      end else if (sh < OMIN) begin
         sat_val = OMIN[CB-1:0];
      end else begin
         sat_val = sh[CB-1:0];
      end
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (qry_acc) state_in = (lim == '0) ? ST_OUT : ST_TRI;
         ST_TRI:      state_in = ST_VTX;
         ST_VTX:      if (cnt_ff == 2'd3) state_in = ST_ISSUE;
         ST_ISSUE: begin
            if ((grp_ff < 3'd3 && cnt_ff == 2'd1) || cnt_ff == 2'd2) state_in = ST_WAIT;
         end
         ST_WAIT:     if (cnt_ff == 2'd1) state_in = ST_STORE;
         ST_STORE: begin
            if (grp_ff == 3'd2) state_in = ST_DG;
            else if (grp_ff == 3'd5) state_in = ST_OUT;
            else state_in = ST_ISSUE;
         end
         ST_DG:       state_in = ST_CHK;
         ST_CHK: begin
            if (tri_ok) state_in = ST_DIVA;
            else if (last_tri) state_in = ST_OUT;
            else state_in = ST_TRI;
         end
         ST_DIVA:     state_in = ST_DIVA_RUN;
         ST_DIVA_RUN: if (!div_busy) state_in = ST_DIVB;
         ST_DIVB:     state_in = ST_DIVB_RUN;
         ST_DIVB_RUN: if (!div_busy) state_in = ST_WG;
         ST_WG:       state_in = ST_ISSUE;
         ST_OUT:      if (out_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---- outputs of the sequencer ----
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      csr_ready = 1'b1;
      mem_ctl.rest_we = req_acc && (req_type == REQ_REST) && vidx_ok;
      mem_ctl.def_we  = req_acc && (req_type == REQ_DEF) && vidx_ok;
      mem_ctl.tri_we  = req_acc && (req_type == REQ_TRI) && tidx_ok;
      mem_ctl.tri_re  = (state_ff == ST_TRI);
      mem_ctl.vtx_re  = (state_ff == ST_VTX) && (cnt_ff != 2'd3);
      mac_ctl.valid = (state_ff == ST_ISSUE);
      mac_ctl.neg   = (grp_ff < 3'd3) && (cnt_ff == 2'd1);
      mac_ctl.first = (cnt_ff == 2'd0);
      div_start = (state_ff == ST_DIVA) || (state_ff == ST_DIVB);
      div_num   = (state_ff == ST_DIVB) ? mag(db_ff) : mag(da_ff);
      div_den   = mag(d_ff);
      case (grp_ff)
         3'd3: begin c0 = dx_ff[0]; c1 = dx_ff[1]; c2 = dx_ff[2]; end
         3'd4: begin c0 = dy_ff[0]; c1 = dy_ff[1]; c2 = dy_ff[2]; end
         default: begin c0 = dz_ff[0]; c1 = dz_ff[1]; c2 = dz_ff[2]; end
      endcase
      ua = '0; va = '0; ub = '0; vb = '0;
      case ({grp_ff, cnt_ff})
         {3'd0, 2'd0}: begin
            ua = MW'(rx_ff[1]); va = MW'(rx_ff[0]); ub = MW'(ry_ff[2]); vb = MW'(ry_ff[0]);
         end
         {3'd0, 2'd1}: begin
            ua = MW'(rx_ff[2]); va = MW'(rx_ff[0]); ub = MW'(ry_ff[1]); vb = MW'(ry_ff[0]);
         end
         {3'd1, 2'd0}: begin
            ua = MW'(rx_ff[1]); va = MW'(px_ff); ub = MW'(ry_ff[2]); vb = MW'(py_ff);
         end
         {3'd1, 2'd1}: begin
            ua = MW'(rx_ff[2]); va = MW'(px_ff); ub = MW'(ry_ff[1]); vb = MW'(py_ff);
         end
         {3'd2, 2'd0}: begin
            ua = MW'(rx_ff[1]); va = MW'(rx_ff[0]); ub = MW'(py_ff); vb = MW'(ry_ff[0]);
         end
         {3'd2, 2'd1}: begin
            ua = MW'(px_ff); va = MW'(rx_ff[0]); ub = MW'(ry_ff[1]); vb = MW'(ry_ff[0]);
         end
         default: begin
            case (cnt_ff)
               2'd0:    begin ua = MW'(wa_ff); ub = MW'(c0); end
               2'd1:    begin ua = MW'(wg_ff); ub = MW'(c1); end
               default: begin ua = MW'(wb_ff); ub = MW'(c2); end
            endcase
         end
      endcase
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         t_ff         <= '0;
         n_ff         <= '0;
         grp_ff       <= '0;
         cnt_ff       <= '0;
         fnd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_triangle_count;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               t_ff   <= '0;
               n_ff   <= TCW'(lim);
               fnd_ff <= 1'b0;
            end
            ST_TRI:   cnt_ff <= '0;
            ST_VTX: begin
               if (cnt_ff == 2'd3) begin
                  cnt_ff <= '0;
                  grp_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 2'd1;
               end
            end
            ST_ISSUE: begin
               if (state_in == ST_WAIT) cnt_ff <= '0;
               else cnt_ff <= cnt_ff + 2'd1;
            end
            ST_WAIT:  cnt_ff <= cnt_ff + 2'd1;
            ST_STORE: begin
               cnt_ff <= '0;
               grp_ff <= grp_ff + 3'd1;
            end
            ST_CHK: begin
               if (tri_ok) fnd_ff <= 1'b1;
               else t_ff <= t_ff + TCW'(1);
            end
            ST_WG: begin
               cnt_ff <= '0;
               grp_ff <= 3'd3;
            end
            default: ;
         endcase
      end
   end

   // ---- datapath registers ----
   always_ff @(posedge clock) begin
      if (qry_acc) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
      end
      if (state_ff == ST_VTX) begin
         // capture the corner read issued in the previous cycle
         for (int k = 0; k < 3; k++) begin
            if (cnt_ff == 2'(k + 1)) begin
               rx_ff[k] <= oob_ff[k] ? '0 : rest_x_q;
               ry_ff[k] <= oob_ff[k] ? '0 : rest_y_q;
               dx_ff[k] <= oob_ff[k] ? '0 : def_x_q;
               dy_ff[k] <= oob_ff[k] ? '0 : def_y_q;
               dz_ff[k] <= oob_ff[k] ? '0 : def_z_q;
            end
            if (cnt_ff == 2'(k)) oob_ff[k] <= corner_oob;
         end
      end
      if (state_ff == ST_STORE) begin
         case (grp_ff)
            3'd0: d_ff  <= $signed(acc[DETW-1:0]);
            3'd1: da_ff <= $signed(acc[DETW-1:0]);
            3'd2: db_ff <= $signed(acc[DETW-1:0]);
            3'd3: ox_ff <= sat_val;
            3'd4: oy_ff <= sat_val;
            default: oz_ff <= sat_val;
         endcase
      end
      if (state_ff == ST_DG) dg_ff <= d_ff - da_ff - db_ff;
      if (state_ff == ST_DIVA_RUN && !div_busy) wa_ff <= div_q;
      if (state_ff == ST_DIVB_RUN && !div_busy) wb_ff <= div_q;
      if (state_ff == ST_WG) wg_ff <= (QBITS'(1) << WFRAC) - wa_ff - wb_ff;
      if (out_load) begin
         rsp_found_ff <= fnd_ff;
         rsp_x_ff     <= fnd_ff ? ox_ff : '0;
         rsp_y_ff     <= fnd_ff ? oy_ff : '0;
         rsp_z_ff     <= fnd_ff ? oz_ff : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_mapped_x = rsp_x_ff;
   assign rsp_mapped_y = rsp_y_ff;
   assign rsp_mapped_z = rsp_z_ff;

   dtpm_mesh #(
      .MAX_VERTICES  (MAX_VERTICES),
      .MAX_TRIANGLES (MAX_TRIANGLES),
      .COORD_BITS    (CB),
      .VAW           (VAW),
      .TAW           (TAW)
   ) u_mesh (
      .clock      (clock),
      .ctl        (mem_ctl),
      .wr_vaddr   (VAW'(req_entry_index)),
      .wr_taddr   (TAW'(req_entry_index)),
      .wr_x       (req_coord_x),
      .wr_y       (req_coord_y),
      .wr_z       (req_coord_z),
      .wr_corners ({req_corner_third, req_corner_second, req_corner_first}),
      .rd_vaddr   (VAW'(corner_sel)),
      .rd_taddr   (t_ff[TAW-1:0]),
      .rest_x_q   (rest_x_q),
      .rest_y_q   (rest_y_q),
      .def_x_q    (def_x_q),
      .def_y_q    (def_y_q),
      .def_z_q    (def_z_q),
      .tri_q      (tri_q)
   );

   dtpm_mac #(
      .MW (MW),
      .AW (AW)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .ua    (ua),
      .va    (va),
      .ub    (ub),
      .vb    (vb),
      .acc   (acc)
   );

   dtpm_div #(
      .DETW (DETW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_q)
   );

`ifndef SYNTHESIS
   a_query_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      qry_acc |=> state_ff != ST_IDLE)
      else $error("query item accepted but sequencer stayed idle");

   a_mac_free_of_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> !div_busy)
      else $error("products issued while the divider is still running");

   a_tri_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRI) |-> (t_ff < n_ff))
      else $error("triangle index beyond search limit");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/dtpm_mesh.sv =====
// Mesh storage: rest and deformed vertex memories and the triangle corner memory.
`default_nettype none
module dtpm_mesh import dtpm_pkg::*; #(
   parameter int MAX_VERTICES  = 1024,
   parameter int MAX_TRIANGLES = 2048,
   parameter int COORD_BITS    = 32,
   parameter int VAW           = 10,
   parameter int TAW           = 11
) (
   input  wire                          clock,
   input  dtpm_mem_ctl_type             ctl,
   input  wire  [VAW-1:0]               wr_vaddr,
   input  wire  [TAW-1:0]               wr_taddr,
   input  wire  signed [COORD_BITS-1:0] wr_x,
   input  wire  signed [COORD_BITS-1:0] wr_y,
   input  wire  signed [COORD_BITS-1:0] wr_z,
   input  wire  [TRI_BITS-1:0]          wr_corners,
   input  wire  [VAW-1:0]               rd_vaddr,
   input  wire  [TAW-1:0]               rd_taddr,
   output logic signed [COORD_BITS-1:0] rest_x_q,
   output logic signed [COORD_BITS-1:0] rest_y_q,
   output logic signed [COORD_BITS-1:0] def_x_q,
   output logic signed [COORD_BITS-1:0] def_y_q,
   output logic signed [COORD_BITS-1:0] def_z_q,
   output logic [TRI_BITS-1:0]          tri_q
);

   logic signed [COORD_BITS-1:0] rest_x_mem [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] rest_y_mem [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] def_x_mem  [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] def_y_mem  [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] def_z_mem  [MAX_VERTICES];
   logic [TRI_BITS-1:0]          tri_mem    [MAX_TRIANGLES];

   always_ff @(posedge clock) begin
      if (ctl.rest_we) begin
         rest_x_mem[wr_vaddr] <= wr_x;
         rest_y_mem[wr_vaddr] <= wr_y;
      end
      if (ctl.def_we) begin
         def_x_mem[wr_vaddr] <= wr_x;
         def_y_mem[wr_vaddr] <= wr_y;
         def_z_mem[wr_vaddr] <= wr_z;
      end
      if (ctl.vtx_re) begin
         rest_x_q <= rest_x_mem[rd_vaddr];
         rest_y_q <= rest_y_mem[rd_vaddr];
         def_x_q  <= def_x_mem[rd_vaddr];
         def_y_q  <= def_y_mem[rd_vaddr];
         def_z_q  <= def_z_mem[rd_vaddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.tri_we) begin
         tri_mem[wr_taddr] <= wr_corners;
      end
      if (ctl.tri_re) begin
         tri_q <= tri_mem[rd_taddr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dtpm_mac.sv =====
// Shared subtract, multiply and accumulate unit, three register stages deep.
`default_nettype none
module dtpm_mac import dtpm_pkg::*; #(
   parameter int MW = 33,
   parameter int AW = 70
) (
   input  wire                   clock,
   input  wire                   reset,
   input  dtpm_mac_ctl_type      ctl,
   input  wire  signed [MW-1:0]  ua,
   input  wire  signed [MW-1:0]  va,
   input  wire  signed [MW-1:0]  ub,
   input  wire  signed [MW-1:0]  vb,
   output logic signed [AW-1:0]  acc
);

   logic signed [MW-1:0]   a_ff;
   logic signed [MW-1:0]   b_ff;
   logic signed [2*MW-1:0] p_ff;
   logic signed [AW-1:0]   acc_ff;
   logic signed [AW-1:0]   base;
   logic signed [AW-1:0]   pext;
   dtpm_mac_ctl_type       c0_ff;
   dtpm_mac_ctl_type       c1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff <= '0;
         c1_ff <= '0;
      end else begin
         c0_ff <= ctl;
         c1_ff <= c0_ff;
      end
   end

   always_comb begin
      base = c1_ff.first ? '0 : acc_ff;
      pext = AW'(p_ff);
   end

   always_ff @(posedge clock) begin
      a_ff <= ua - va;
      b_ff <= ub - vb;
      p_ff <= a_ff * b_ff;
      if (c1_ff.valid) begin
         acc_ff <= c1_ff.neg ? base - pext : base + pext;
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

// ===== rtl/core/dtpm_div.sv =====
// Restoring divider giving floor(num * 2^30 / den) one quotient bit per cycle.
`default_nettype none
module dtpm_div import dtpm_pkg::*; #(
   parameter int DETW = 69
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire  [DETW-1:0]   num,
   input  wire  [DETW-1:0]   den,
   output logic              busy,
   output logic [QBITS-1:0]  quot
);

   localparam int SW = $clog2(QBITS);

   logic              busy_ff;
   logic [SW-1:0]     step_ff;
   logic [DETW:0]     rem_ff;
   logic [DETW-1:0]   den_ff;
   logic [QBITS-1:0]  q_ff;
   logic [DETW:0]     trial;
   logic              ge;

   always_comb begin
      trial = (step_ff == '0) ? rem_ff : {rem_ff[DETW-1:0], 1'b0};
      ge    = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + SW'(1);
         if (step_ff == SW'(QBITS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num};
         den_ff <= den;
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial - {1'b0, den_ff} : trial;
         q_ff   <= {q_ff[QBITS-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

// ===== bench/dtpm_checker.sv =====
// Checker for the triangle point map: mirrors the mesh, predicts each query, compares responses.
`timescale 1ns / 1ps
module dtpm_checker import dtpm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [IDX_BITS-1:0] req_entry_index,
   input  logic signed [31:0]  req_coord_x,
   input  logic signed [31:0]  req_coord_y,
   input  logic signed [31:0]  req_coord_z,
   input  logic [9:0]          req_corner_first,
   input  logic [9:0]          req_corner_second,
   input  logic [9:0]          req_corner_third,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_found,
   input  logic signed [31:0]  rsp_mapped_x,
   input  logic signed [31:0]  rsp_mapped_y,
   input  logic signed [31:0]  rsp_mapped_z,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [CNT_BITS-1:0] csr_triangle_count,
   output int                  errors,
   output int                  pending,
   output int                  answered,
   output int                  hits
);

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic               found;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } mapped_point_type;

   mapped_point_type   mapped_due[$];
   logic signed [31:0] rest_x_m [0:1023];
   logic signed [31:0] rest_y_m [0:1023];
   logic signed [31:0] def_x_m [0:1023];
   logic signed [31:0] def_y_m [0:1023];
   logic signed [31:0] def_z_m [0:1023];
   logic [29:0]        corners_m [0:2047];
   logic [CNT_BITS-1:0] tri_count;

   function automatic wide_type cross2(wide_type ax, wide_type ay, wide_type bx, wide_type by);
      return ax * by - bx * ay;
   endfunction

   function automatic logic agrees(wide_type d, wide_type v);
      return (v == 0) || (v[127] == d[127]);
   endfunction

   // floor(|n| * 2^30 / |d|)
   function automatic wide_type weight(wide_type n, wide_type d);
      logic [127:0] an, ad;
      an = n[127] ? -n : n;
      ad = d[127] ? -d : d;
      return wide_type'((an << WFRAC) / ad);
   endfunction

   function automatic logic signed [31:0] blend(wide_type wa, wide_type c0, wide_type wg,
                                                wide_type c1, wide_type wb, wide_type c2);
      wide_type s, max_c, min_c;
      max_c = 128'sh7fffffff;
      min_c = -128'sh80000000;
      s = wa * c0 + wg * c1 + wb * c2 + (wide_type'(1) <<< (WFRAC - 1));
      s = s >>> WFRAC;
      if (s > max_c) return 32'sh7fffffff;
      if (s < min_c) return 32'sh80000000;
      return s[31:0];
   endfunction

   function automatic mapped_point_type map_point(logic signed [31:0] qx,
                                                  logic signed [31:0] qy);
      mapped_point_type r;
      int            n, t, k;
      logic [9:0]    v [3];
      wide_type      x [3];
      wide_type      y [3];
      wide_type      px, py, d, da, db, dg, wa, wb, wg;
      r.found = 1'b0;
      r.x = 0;
      r.y = 0;
      r.z = 0;
      px = qx;
      py = qy;
      n = (tri_count > 2048) ? 2048 : int'(tri_count);
      for (t = 0; t < n; t++) begin
         for (k = 0; k < 3; k++) begin
            v[k] = corners_m[t][10*k +: 10];
            x[k] = rest_x_m[v[k]];
            y[k] = rest_y_m[v[k]];
         end
         d = cross2(x[1] - x[0], y[1] - y[0], x[2] - x[0], y[2] - y[0]);
         if (d == 0) continue;
         da = cross2(x[1] - px, y[1] - py, x[2] - px, y[2] - py);
         db = cross2(x[1] - x[0], y[1] - y[0], px - x[0], py - y[0]);
         dg = d - da - db;
         if (!agrees(d, da) || !agrees(d, db) || !agrees(d, dg)) continue;
         wa = weight(da, d);
         wb = weight(db, d);
         wg = (wide_type'(1) <<< WFRAC) - wa - wb;
         r.found = 1'b1;
         r.x = blend(wa, def_x_m[v[0]], wg, def_x_m[v[1]], wb, def_x_m[v[2]]);
         r.y = blend(wa, def_y_m[v[0]], wg, def_y_m[v[1]], wb, def_y_m[v[2]]);
         r.z = blend(wa, def_z_m[v[0]], wg, def_z_m[v[1]], wb, def_z_m[v[2]]);
         break;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      mapped_point_type want;
      if (reset) begin
         errors = 0;
         pending = 0;
         answered = 0;
         hits = 0;
         tri_count = '0;
         mapped_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mapped_due.size() == 0) begin
               errors = errors + 1;
               $display("%0t: response with no query waiting: found %0b (%h %h %h)",
                        $time, rsp_found, rsp_mapped_x, rsp_mapped_y, rsp_mapped_z);
            end else begin
               want = mapped_due.pop_front();
               answered = answered + 1;
               if (want.found) hits = hits + 1;
               if (rsp_found !== want.found) begin
                  errors = errors + 1;
                  $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_found);
               end
               if (rsp_mapped_x !== want.x) begin
                  errors = errors + 1;
                  $display("%0t: mapped_x expected %h actual %h", $time, want.x, rsp_mapped_x);
               end
               if (rsp_mapped_y !== want.y) begin
                  errors = errors + 1;
                  $display("%0t: mapped_y expected %h actual %h", $time, want.y, rsp_mapped_y);
               end
               if (rsp_mapped_z !== want.z) begin
                  errors = errors + 1;
                  $display("%0t: mapped_z expected %h actual %h", $time, want.z, rsp_mapped_z);
               end
            end
         end
         if (csr_valid && csr_ready) tri_count = csr_triangle_count;
         if (req_valid && req_ready) begin
            case (dtpm_req_code_type'(req_type))
               REQ_REST: begin
                  if (req_entry_index < 1024) begin
                     rest_x_m[req_entry_index[9:0]] = req_coord_x;
                     rest_y_m[req_entry_index[9:0]] = req_coord_y;
                  end
               end
               REQ_DEF: begin
                  if (req_entry_index < 1024) begin
                     def_x_m[req_entry_index[9:0]] = req_coord_x;
                     def_y_m[req_entry_index[9:0]] = req_coord_y;
                     def_z_m[req_entry_index[9:0]] = req_coord_z;
                  end
               end
               REQ_TRI: begin
                  corners_m[req_entry_index] =
                     {req_corner_third, req_corner_second, req_corner_first};
               end
               default: begin
                  mapped_due = {mapped_due, map_point(req_coord_x, req_coord_y)};
               end
            endcase
         end
         pending = mapped_due.size();
      end
   end

endmodule

// ===== bench/tb_deformed_triangle_point_map.sv =====
// Testbench top for the triangle point map: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_deformed_triangle_point_map;
   import dtpm_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_type = REQ_REST;
   logic [IDX_BITS-1:0] req_entry_index = '0;
   logic signed [31:0]  req_coord_x = '0;
   logic signed [31:0]  req_coord_y = '0;
   logic signed [31:0]  req_coord_z = '0;
   logic [9:0]          req_corner_first = '0;
   logic [9:0]          req_corner_second = '0;
   logic [9:0]          req_corner_third = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic signed [31:0]  rsp_mapped_x;
   logic signed [31:0]  rsp_mapped_y;
   logic signed [31:0]  rsp_mapped_z;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_BITS-1:0] csr_triangle_count = '0;
   int                  errors, pending, answered, hits;

   // mirror of what was written, used to aim query points and pick triangle corners
   longint  rest_xs [0:1023];
   longint  rest_ys [0:1023];
   bit      rest_ok [0:1023];
   bit      def_ok [0:1023];
   int      usable_vertices[$];
   int      tri_corner [0:2047][3];
   int      tris_loaded = 0;
   int      cur_count = 0;
   int      sent = 0;
   int      received = 0;

   always #5 clock = ~clock;

   deformed_triangle_point_map uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_entry_index(req_entry_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_corner_first(req_corner_first), .req_corner_second(req_corner_second),
      .req_corner_third(req_corner_third),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_found(rsp_found),
      .rsp_mapped_x(rsp_mapped_x), .rsp_mapped_y(rsp_mapped_y),
      .rsp_mapped_z(rsp_mapped_z),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_triangle_count(csr_triangle_count)
   );

   dtpm_checker check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_entry_index(req_entry_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_corner_first(req_corner_first), .req_corner_second(req_corner_second),
      .req_corner_third(req_corner_third),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_found(rsp_found),
      .rsp_mapped_x(rsp_mapped_x), .rsp_mapped_y(rsp_mapped_y),
      .rsp_mapped_z(rsp_mapped_z),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_triangle_count(csr_triangle_count),
      .errors(errors), .pending(pending), .answered(answered), .hits(hits)
   );

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: random stalls, stretches with none, one long hold-off
   initial begin : rsp_side
      int gap;
      @(negedge clock iff !reset);
      forever begin
         gap = ((received / 16) % 3 == 0) ? 0 : $urandom_range(0, 15);
         if (received == 8) gap = 700;
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         received++;
         @(negedge clock);
      end
   end

   task automatic send(dtpm_req_code_type kind, int idx, logic [31:0] x, logic [31:0] y,
                       logic [31:0] z, int c0, int c1, int c2);
      int gap;
      gap = ((sent / 16) % 3 == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = kind;
      req_entry_index = IDX_BITS'(idx);
      req_coord_x = x;
      req_coord_y = y;
      req_coord_z = z;
      req_corner_first = 10'(c0);
      req_corner_second = 10'(c1);
      req_corner_third = 10'(c2);
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   task automatic note_vertex(int idx);
      if (idx < 1024 && rest_ok[idx] && def_ok[idx]) begin
         foreach (usable_vertices[i]) if (usable_vertices[i] == idx) return;
         usable_vertices = {usable_vertices, idx};
      end
   endtask

   task automatic write_rest(int idx, logic signed [31:0] x, logic signed [31:0] y);
      send(REQ_REST, idx, x, y, $urandom, $urandom_range(0, 1023),
           $urandom_range(0, 1023), $urandom_range(0, 1023));
      if (idx < 1024) begin
         rest_xs[idx] = x;
         rest_ys[idx] = y;
         rest_ok[idx] = 1'b1;
         note_vertex(idx);
      end
   endtask

   task automatic write_def(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      send(REQ_DEF, idx, x, y, z, $urandom_range(0, 1023), $urandom_range(0, 1023),
           $urandom_range(0, 1023));
      if (idx < 1024) begin
         def_ok[idx] = 1'b1;
         note_vertex(idx);
      end
   endtask

   task automatic write_tri(int idx, int c0, int c1, int c2);
      send(REQ_TRI, idx, $urandom, $urandom, $urandom, c0, c1, c2);
      tri_corner[idx][0] = c0;
      tri_corner[idx][1] = c1;
      tri_corner[idx][2] = c2;
      if (idx == tris_loaded) tris_loaded++;
   endtask

   task automatic query(logic [31:0] x, logic [31:0] y);
      send(REQ_QUERY, $urandom_range(0, 2047), x, y, $urandom, $urandom_range(0, 1023),
           $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   task automatic set_count(int value);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_valid = 1'b1;
      csr_triangle_count = CNT_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      cur_count = value;
   endtask

   function automatic logic [31:0] rand_coord();
      int v;
      if ($urandom_range(0, 3) == 0) return $urandom;
      v = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      return v;
   endfunction

   function automatic int pick_vertex();
      return usable_vertices[$urandom_range(0, usable_vertices.size() - 1)];
   endfunction

   // aim mostly at loaded triangles: corners, edges, interior, else anywhere
   task automatic random_query();
      int     n, t, k, a, b, c, w0, w1, w2;
      longint qx, qy;
      n = (cur_count > 2048) ? 2048 : cur_count;
      k = $urandom_range(0, 99);
      qx = $signed(rand_coord());
      qy = $signed(rand_coord());
      if (n > 0 && k < 75) begin
         t = $urandom_range(0, n - 1);
         a = tri_corner[t][0];
         b = tri_corner[t][1];
         c = tri_corner[t][2];
         if (k < 15) begin
            qx = rest_xs[b];
            qy = rest_ys[b];
         end else if (k < 25) begin
            qx = (rest_xs[a] + rest_xs[c]) / 2;
            qy = (rest_ys[a] + rest_ys[c]) / 2;
         end else begin
            w0 = $urandom_range(0, 16);
            w1 = $urandom_range(0, 16 - w0);
            w2 = 16 - w0 - w1;
            qx = (w0 * rest_xs[a] + w1 * rest_xs[b] + w2 * rest_xs[c]) / 16;
            qy = (w0 * rest_ys[a] + w1 * rest_ys[b] + w2 * rest_ys[c]) / 16;
         end
      end
      query(qx[31:0], qy[31:0]);
   endtask

   task automatic random_item();
      int k, idx;
      k = $urandom_range(0, 99);
      if (k < 30) begin
         idx = $urandom_range(0, 9);
         idx = (idx < 7) ? $urandom_range(0, 63) :
               (idx < 9) ? $urandom_range(0, 1023) : $urandom_range(1024, 2047);
         if ($urandom_range(0, 1)) write_rest(idx, rand_coord(), rand_coord());
         else write_def(idx, rand_coord(), rand_coord(), rand_coord());
      end else if (k < 50) begin
         idx = (tris_loaded < 2048 && $urandom_range(0, 9) < 6) ?
               tris_loaded : $urandom_range(0, tris_loaded - 1);
         if ($urandom_range(0, 9) == 0) begin
            k = pick_vertex();
            write_tri(idx, k, k, pick_vertex());
         end else begin
            write_tri(idx, pick_vertex(), pick_vertex(), pick_vertex());
         end
      end else begin
         random_query();
      end
   endtask

   initial begin : stimulus
      int phase, i;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty mesh: nothing to find
      set_count(0);
      query(32'h8000_0000, 32'h7fff_ffff);

      write_rest(0, 0, 0);
      write_def(0, 32'h7fff_ffff, 32'h8000_0000, 0);
      write_rest(1, 32'h1000_0000, 0);
      write_def(1, 32'h0800_0000, 32'hf000_0000, 32'h1234_5678);
      write_rest(2, 0, 32'h1000_0000);
      write_def(2, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      write_rest(1023, 32'h7fff_ffff, 32'h7fff_ffff);
      write_def(1023, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      write_rest(3, 32'h8000_0000, 32'h8000_0000);
      write_def(3, $urandom, $urandom, $urandom);
      // out-of-range vertex writes are dropped
      write_rest(2047, 32'h5555_5555, 32'haaaa_aaaa);
      write_def(1024, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff);
      write_tri(0, 3, 3, 0);          // degenerate: skipped
      write_tri(1, 0, 1, 2);
      write_tri(2, 3, 1023, 1);
      write_tri(2047, 1023, 2, 0);
      set_count(3);
      query(0, 0);                     // shared corner
      query(32'h0800_0000, 32'h0800_0000);  // on the hypotenuse
      query(32'h0400_0000, 32'h0200_0000);  // interior
      query(32'hffff_ffff, 32'hffff_ffff);
      query(32'h7fff_ffff, 32'h8000_0000);
      query(32'h7fff_ffff, 32'h7fff_ffff);

      for (phase = 0; phase < 4; phase++) begin
         set_count((phase == 1) ? 1 : $urandom_range(1, tris_loaded));
         for (i = 0; i < 20; i++) random_item();
      end

      // count above the store size: aim inside triangle 0 so the search ends there
      write_rest(0, 0, 0);
      write_rest(1, 32'h1000_0000, 0);
      write_rest(2, 0, 32'h1000_0000);
      write_tri(0, 0, 1, 2);
      set_count(4095);
      query(32'h0400_0000, 32'h0200_0000);
      query(32'h0100_0000, 32'h0c00_0000);

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      $display("Covered %0d accepted items: %0d queries answered, %0d mapped inside a triangle.",
               sent, answered, hits);
      $display("Triangle counts from 0 up to 4095, with stalls on both sides.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
